[rtl/esf_pkg.sv]
// Shared types, constants and helpers for the exchange field stencil engine.
// Used by esf_div and exchange_field_stencil_engine; depends on nothing.
package esf_pkg;

  // Grid geometry
  localparam int GRID_SIDE = 32;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int SIZE_W    = COORD_W + 1;
  localparam int ADDR_W    = 3 * COORD_W;

  // Field formats
  localparam int MAG_BITS  = 16;
  localparam int MS_W      = 24;
  localparam int WGT_W     = 32;
  localparam int STIFF_W   = 48;
  localparam int FIELD_W   = 32;
  localparam int ENTRY_W   = 3 * MAG_BITS + MS_W;

  // Datapath widths
  localparam int D_W       = MAG_BITS + 3;     // per-axis second difference
  localparam int ACC_W     = MAG_BITS + 36;    // signed Laplacian sum
  localparam int AMAG_W    = MAG_BITS + 35;    // its magnitude
  localparam int MUL_W     = 32;               // shared multiplier operand width
  localparam int P_W       = AMAG_W + STIFF_W; // scaled product
  localparam int OUT_SHIFT = MAG_BITS + 23;
  localparam int V_W       = P_W - OUT_SHIFT;  // dividend before division
  localparam int Q_W       = 33;               // quotient bits kept
  localparam int NUM_W     = MS_W + Q_W;       // dividend bits when quotient fits

  // Request codes
  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  // Boundary codes
  localparam logic [1:0] BC_OPEN     = 2'd0;
  localparam logic [1:0] BC_PERIODIC = 2'd1;
  localparam logic [1:0] BC_MIRROR   = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_GRID_X  = 3'd0;
  localparam logic [2:0] REG_GRID_Y  = 3'd1;
  localparam logic [2:0] REG_GRID_Z  = 3'd2;
  localparam logic [2:0] REG_INV_DX2 = 3'd3;
  localparam logic [2:0] REG_INV_DY2 = 3'd4;
  localparam logic [2:0] REG_INV_DZ2 = 3'd5;
  localparam logic [2:0] REG_STIFF   = 3'd6;
  localparam logic [2:0] REG_BC_MODE = 3'd7;

  // Clamp a grid size register to the usable range
  function automatic logic [SIZE_W-1:0] eff_size(input logic [5:0] r);
    logic [SIZE_W-1:0] s;
    if (r == 6'd0) begin
      s = SIZE_W'(1);
    end else if (SIZE_W'(r) > SIZE_W'(GRID_SIDE) || r > 6'(GRID_SIDE)) begin
      s = SIZE_W'(GRID_SIDE);
    end else begin
      s = SIZE_W'(r);
    end
    return s;
  endfunction

endpackage

[rtl/esf_div.sv]
// Restoring divider, one quotient bit per cycle, for the field scaling.
// Depends on esf_pkg for widths.
module esf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [esf_pkg::NUM_W-1:0]    num,
  input  logic [esf_pkg::MS_W-1:0]     den,
  output logic                         fin,
  output logic [esf_pkg::Q_W-1:0]      quo
);

  logic [esf_pkg::MS_W-1:0] rem;
  logic [esf_pkg::Q_W-1:0]  low;
  logic [5:0]               cnt;
  logic [esf_pkg::MS_W:0]   trial;
  logic                     ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem, low[esf_pkg::Q_W-1]};
    ge    = trial >= {1'b0, den};
  end

  // Load on go, then retire one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        rem <= num[esf_pkg::NUM_W-1:esf_pkg::Q_W];
        low <= num[esf_pkg::Q_W-1:0];
        cnt <= 6'(esf_pkg::Q_W);
      end else if (cnt != 6'd0) begin
        rem <= ge ? esf_pkg::MS_W'(trial - {1'b0, den}) : trial[esf_pkg::MS_W-1:0];
        low <= {low[esf_pkg::Q_W-2:0], 1'b0};
        quo <= {quo[esf_pkg::Q_W-2:0], ge};
        cnt <= cnt - 6'd1;
        fin <= (cnt == 6'd1);
      end
    end
  end

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt != 6'd0 && !go) |-> rem < den) else $error("divider remainder out of range");
  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    fin |=> !fin) else $error("divider finish not a single pulse");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    fin |-> cnt == 6'd0) else $error("divider finished while counting");

endmodule

[rtl/exchange_field_stencil_engine.sv]
// Exchange field stencil engine: a compute inside the grid keeps busy high
// while it reads the seven cells and then, per component, forms 3 weight
// products, 4 scaling partial products and a 33-step divide on the shared
// multiplier and divider (the divide is skipped for a zero saturation
// magnetization or an overflow); it then raises done for one cycle with the
// field. Results cannot be stalled; busy is high for the whole compute.
// A compute outside the in-use grid gives no result.
// Depends on esf_pkg and esf_div.
module exchange_field_stencil_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type,
  input  logic [esf_pkg::COORD_W-1:0]       cell_x,
  input  logic [esf_pkg::COORD_W-1:0]       cell_y,
  input  logic [esf_pkg::COORD_W-1:0]       cell_z,
  input  logic signed [esf_pkg::MAG_BITS-1:0] mag_x,
  input  logic signed [esf_pkg::MAG_BITS-1:0] mag_y,
  input  logic signed [esf_pkg::MAG_BITS-1:0] mag_z,
  input  logic [esf_pkg::MS_W-1:0]          cell_ms,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [esf_pkg::STIFF_W-1:0]       cfg_data,
  output logic                              done,
  output logic signed [esf_pkg::FIELD_W-1:0] field_x,
  output logic signed [esf_pkg::FIELD_W-1:0] field_y,
  output logic signed [esf_pkg::FIELD_W-1:0] field_z,
  output logic                              saturated
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LAP, S_MAG, S_SCALE, S_CHECK, S_DIV, S_FIN
  } state_t;

  localparam int CW = esf_pkg::COORD_W;
  localparam int SW = esf_pkg::SIZE_W;
  localparam int MB = esf_pkg::MAG_BITS;

  // Configuration
  logic [5:0]                   grid_reg [3];
  logic [esf_pkg::WGT_W-1:0]    inv_d2 [3];
  logic [esf_pkg::STIFF_W-1:0]  stiff;
  logic [1:0]                   bc_mode;

  // Sequencer and datapath
  state_t                       state;
  logic [2:0]                   rcnt;
  logic [2:0]                   tcnt;
  logic [1:0]                   comp;
  logic [CW-1:0]                cur [3];
  logic signed [esf_pkg::D_W-1:0] dval [3][3];
  logic [esf_pkg::MS_W-1:0]     ms_cur;
  logic signed [esf_pkg::ACC_W-1:0] acc;
  logic [esf_pkg::AMAG_W-1:0]   amag;
  logic                         neg;
  logic [esf_pkg::P_W-1:0]      p_acc;
  logic [63:0]                  mul_p;
  logic                         mul_neg;
  logic [6:0]                   mul_sh;
  logic                         big;
  logic                         zero_ms;
  logic                         sat_acc;
  logic                         rd_live;
  logic [2:0]                   rd_tag;
  logic                         rd_use;

  // Memory
  logic [esf_pkg::ENTRY_W-1:0]  mem [1 << esf_pkg::ADDR_W];
  logic [esf_pkg::ENTRY_W-1:0]  mem_q;

  // Combinational
  logic [SW-1:0]                nsz [3];
  logic                         in_grid;
  logic                         wr_en;
  logic [MB-1:0]                q_mag [3];
  logic [CW-1:0]                nb_co [3];
  logic                         nb_ok;
  logic [esf_pkg::ADDR_W-1:0]   raddr;
  logic [esf_pkg::MUL_W-1:0]    mul_a;
  logic [esf_pkg::MUL_W-1:0]    mul_b;
  logic                         mul_sgn;
  logic [6:0]                   mul_sh_next;
  logic [esf_pkg::V_W-1:0]      vq;
  logic                         big_next;
  logic                         div_go;
  logic                         div_fin;
  logic [esf_pkg::Q_W-1:0]      div_quo;
  logic [esf_pkg::FIELD_W-1:0]  res;
  logic                         res_sat;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // Effective sizes and input address check
  always_comb begin
    nsz[0]  = esf_pkg::eff_size(grid_reg[0]);
    nsz[1]  = esf_pkg::eff_size(grid_reg[1]);
    nsz[2]  = esf_pkg::eff_size(grid_reg[2]);
    in_grid = ({1'b0, cell_x} < nsz[0]) && ({1'b0, cell_y} < nsz[1])
              && ({1'b0, cell_z} < nsz[2]);
    wr_en   = start && !busy && (req_type == esf_pkg::REQ_WRITE) && in_grid;
  end

  // Neighbor address for read slot rcnt: self, then x-, x+, y-, y+, z-, z+
  always_comb begin
    logic [2:0]    sl;
    logic [1:0]    ax;
    logic          up;
    logic [CW-1:0] c;
    logic [SW-1:0] n;
    logic          at_edge;
    sl      = rcnt - 3'd1;
    ax      = sl[2:1];
    up      = sl[0];
    c       = cur[0];
    n       = nsz[0];
    at_edge = 1'b0;
    nb_co   = cur;
    nb_ok   = 1'b1;
    if (rcnt != 3'd0 && rcnt != 3'd7) begin
      c       = cur[ax];
      n       = nsz[ax];
      at_edge = up ? (({1'b0, c} + SW'(1)) >= n) : (c == '0);
      if (!at_edge) begin
        nb_co[ax] = up ? CW'(c + CW'(1)) : CW'(c - CW'(1));
      end else if (bc_mode == esf_pkg::BC_PERIODIC) begin
        nb_co[ax] = up ? '0 : CW'(n - SW'(1));
      end else if (bc_mode == esf_pkg::BC_MIRROR) begin
        nb_co[ax] = c;
      end else begin
        nb_ok = 1'b0;
      end
    end
    raddr = {nb_co[2], nb_co[1], nb_co[0]};
  end

  // Cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{cell_z, cell_y, cell_x}] <= {cell_ms, mag_z, mag_y, mag_x};
    end
    mem_q <= mem[raddr];
  end

  always_comb begin
    q_mag[0] = mem_q[MB-1:0];
    q_mag[1] = mem_q[2*MB-1:MB];
    q_mag[2] = mem_q[3*MB-1:2*MB];
  end

  // Shared multiplier operand select
  always_comb begin
    logic signed [esf_pkg::D_W-1:0] d;
    logic signed [esf_pkg::D_W-1:0] dabs;
    d           = dval[0][comp];
    dabs        = '0;
    mul_a       = '0;
    mul_b       = '0;
    mul_sgn     = 1'b0;
    mul_sh_next = '0;
    if (state == S_LAP && tcnt < 3'd3) begin
      d       = dval[tcnt[1:0]][comp];
      dabs    = d[esf_pkg::D_W-1] ? -d : d;
      mul_a   = esf_pkg::MUL_W'(unsigned'(dabs));
      mul_b   = inv_d2[tcnt[1:0]];
      mul_sgn = d[esf_pkg::D_W-1];
    end else if (state == S_SCALE && tcnt < 3'd4) begin
      mul_a = tcnt[1] ? esf_pkg::MUL_W'(amag[esf_pkg::AMAG_W-1:32]) : amag[31:0];
      mul_b = tcnt[0] ? esf_pkg::MUL_W'(stiff[esf_pkg::STIFF_W-1:32]) : stiff[31:0];
      if (tcnt[1] && tcnt[0]) begin
        mul_sh_next = 7'd64;
      end else if (tcnt[1] || tcnt[0]) begin
        mul_sh_next = 7'd32;
      end
    end
  end

  // Register the product for the accumulate step
  always_ff @(posedge clk) begin
    mul_p   <= 64'(mul_a) * 64'(mul_b);
    mul_neg <= mul_sgn;
    mul_sh  <= mul_sh_next;
  end

  // Overflow check before dividing
  always_comb begin
    vq       = p_acc[esf_pkg::P_W-1:esf_pkg::OUT_SHIFT];
    big_next = (esf_pkg::V_W - esf_pkg::Q_W)'(vq[esf_pkg::V_W-1:esf_pkg::Q_W])
               >= (esf_pkg::V_W - esf_pkg::Q_W)'(ms_cur);
    div_go   = (state == S_CHECK) && (ms_cur != '0) && !big_next;
  end

  esf_div u_div (
    .clk (clk),
    .rst (rst),
    .go  (div_go),
    .num (vq[esf_pkg::NUM_W-1:0]),
    .den (ms_cur),
    .fin (div_fin),
    .quo (div_quo)
  );

  // Sign and clip the quotient
  always_comb begin
    res     = '0;
    res_sat = 1'b0;
    if (zero_ms) begin
      res = '0;
    end else if (!neg) begin
      if (big || div_quo[esf_pkg::Q_W-1:31] != 2'd0) begin
        res     = 32'h7FFF_FFFF;
        res_sat = 1'b1;
      end else begin
        res = div_quo[31:0];
      end
    end else begin
      if (big || div_quo > 33'h0_8000_0000) begin
        res     = 32'h8000_0000;
        res_sat = 1'b1;
      end else begin
        res = 32'(-div_quo[31:0]);
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_reg[0] <= 6'(esf_pkg::GRID_SIDE);
      grid_reg[1] <= 6'(esf_pkg::GRID_SIDE);
      grid_reg[2] <= 6'(esf_pkg::GRID_SIDE);
      inv_d2[0]   <= 32'd65536;
      inv_d2[1]   <= 32'd65536;
      inv_d2[2]   <= 32'd65536;
      stiff       <= '0;
      bc_mode     <= esf_pkg::BC_OPEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        esf_pkg::REG_GRID_X:  grid_reg[0] <= cfg_data[5:0];
        esf_pkg::REG_GRID_Y:  grid_reg[1] <= cfg_data[5:0];
        esf_pkg::REG_GRID_Z:  grid_reg[2] <= cfg_data[5:0];
        esf_pkg::REG_INV_DX2: inv_d2[0]   <= cfg_data[31:0];
        esf_pkg::REG_INV_DY2: inv_d2[1]   <= cfg_data[31:0];
        esf_pkg::REG_INV_DZ2: inv_d2[2]   <= cfg_data[31:0];
        esf_pkg::REG_STIFF:   stiff       <= cfg_data;
        esf_pkg::REG_BC_MODE: bc_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, datapath registers and result outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rcnt      <= '0;
      tcnt      <= '0;
      comp      <= '0;
      rd_live   <= 1'b0;
      done      <= 1'b0;
      saturated <= 1'b0;
      sat_acc   <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_live <= (state == S_READ) && (rcnt != 3'd7);
      rd_tag  <= rcnt;
      rd_use  <= nb_ok;

      // Fold returning read data into the second differences
      if (rd_live) begin
        if (rd_tag == 3'd0) begin
          ms_cur <= mem_q[esf_pkg::ENTRY_W-1:3*MB];
          for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
              dval[a][k] <= -(esf_pkg::D_W'(signed'(q_mag[k])) <<< 1);
            end
          end
        end else if (rd_use) begin
          for (int k = 0; k < 3; k++) begin
            dval[2'((rd_tag - 3'd1) >> 1)][k] <= dval[2'((rd_tag - 3'd1) >> 1)][k]
                                              + esf_pkg::D_W'(signed'(q_mag[k]));
          end
        end
      end

      case (state)
        S_IDLE: begin
          if (start && req_type == esf_pkg::REQ_COMPUTE && in_grid) begin
            cur[0]  <= cell_x;
            cur[1]  <= cell_y;
            cur[2]  <= cell_z;
            rcnt    <= '0;
            comp    <= '0;
            sat_acc <= 1'b0;
            state   <= S_READ;
          end
        end
        S_READ: begin
          rcnt <= rcnt + 3'd1;
          if (rcnt == 3'd7) begin
            tcnt  <= '0;
            state <= S_LAP;
          end
        end
        S_LAP: begin
          // Accumulate the weighted axis terms
          if (tcnt == 3'd0) begin
            acc <= '0;
          end else if (mul_neg) begin
            acc <= acc - esf_pkg::ACC_W'(mul_p);
          end else begin
            acc <= acc + esf_pkg::ACC_W'(mul_p);
          end
          tcnt <= tcnt + 3'd1;
          if (tcnt == 3'd3) begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          neg   <= acc[esf_pkg::ACC_W-1];
          amag  <= acc[esf_pkg::ACC_W-1] ? esf_pkg::AMAG_W'(-acc) : esf_pkg::AMAG_W'(acc);
          tcnt  <= '0;
          state <= S_SCALE;
        end
        S_SCALE: begin
          // Sum the four partial products of magnitude times stiffness
          if (tcnt == 3'd0) begin
            p_acc <= '0;
          end else begin
            p_acc <= p_acc + (esf_pkg::P_W'(mul_p) << mul_sh);
          end
          tcnt <= tcnt + 3'd1;
          if (tcnt == 3'd4) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          zero_ms <= (ms_cur == '0);
          big     <= big_next;
          state   <= div_go ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_fin) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          case (comp)
            2'd0:    field_x <= res;
            2'd1:    field_y <= res;
            default: field_z <= res;
          endcase
          sat_acc <= sat_acc | res_sat;
          if (comp == 2'd2) begin
            saturated <= sat_acc | res_sat;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            comp  <= comp + 2'd1;
            tcnt  <= '0;
            state <= S_LAP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result strobe leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");
  // An in-grid compute transfer starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == esf_pkg::REQ_COMPUTE && in_grid) |=> busy)
    else $error("compute transfer did not start");
  // The divider only runs with a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ms_cur != '0) else $error("divide by zero saturation");
  // No memory write during a compute
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en) else $error("cell write while busy");

endmodule
